### sv/assert_macros.svh
// Assertion macros used by the RTL of the onset detector.
// Define NO_ASSERTIONS to compile all of them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### sv/tocd_pkg.sv
// Package of the transient onset capture detector.
// Holds the sequencer states, register indexes and fixed-point constants.
`default_nettype none

package tocd_pkg;

  typedef enum logic [3:0] {
    StIdle,
    StDecay,
    StSensHi,
    StSensLo,
    StSlowHi,
    StSlowLo,
    StRearmThr,
    StRearmPeak,
    StDecide,
    StGate
  } tocd_state_e;

  typedef enum logic [2:0] {
    CfgThreshold = 3'd0,
    CfgSensitivity = 3'd1,
    CfgHold = 3'd2,
    CfgMaxCapture = 3'd3,
    CfgGateEnable = 3'd4,
    CfgTriggerMode = 3'd5,
    CfgFastDecay = 3'd6,
    CfgSlowRate = 3'd7
  } tocd_cfg_e;

  localparam logic [1:0] ModeAudio = 2'd0;
  localparam logic [1:0] ModeMidi = 2'd1;

  localparam logic [15:0] KRearmThr = 16'd45875;
  localparam logic [15:0] KRearmPeak = 16'd22938;
  localparam logic [15:0] KGate = 16'd1311;

  localparam logic [19:0] SinceMax = 20'hFFFFF;

endpackage

`default_nettype wire

### sv/transient_onset_capture_detector_unit.sv
// Top level of the transient onset capture detector.
// Depends on tocd_pkg and assert_macros.svh.
//
// One stereo sample request is accepted while the unit is idle and yields one
// result request at the end of the sequence; the next sample can be accepted in
// the cycle after the result is registered, so no new sample is taken before the
// last one is through. A small sequencer uses the single shared 24 x 24
// multiplier eight times per sample for the envelope decay, the slow envelope
// step, the sensitivity product and the re-arm and gate levels. A result waits
// in an output register while the next sample is processed; a finished sample
// holds in its last step only if that register is still full.
`default_nettype none
`include "assert_macros.svh"

module transient_onset_capture_detector_unit
  import tocd_pkg::*;
#(
  parameter int PREROLL_SAMPLES = 288,
  parameter int MIN_KEEP_SAMPLES = 480,
  parameter int GATE_DELAY_SAMPLES = 1440,
  parameter int CAPTURE_DEPTH = 65536
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [23:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [23:0] left_sample_i,
  input  wire logic signed [23:0] right_sample_i,
  input  wire logic               note_trigger_i,
  input  wire logic               manual_trigger_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    onset_o,
  output logic                    capturing_o,
  output logic                    capture_done_o,
  output logic                    capture_kept_o,
  output logic [16:0]             capture_length_o,
  output logic [23:0]             envelope_level_o
);

  localparam logic [16:0] MinKeep = 17'(MIN_KEEP_SAMPLES);
  localparam logic [16:0] GateDelay = 17'(GATE_DELAY_SAMPLES);
  localparam logic [16:0] DepthLimit = 17'(CAPTURE_DEPTH - 1);
  localparam logic [9:0] PrerollMax = 10'(PREROLL_SAMPLES);

  tocd_state_e state_q, state_d;

  logic [23:0] thr_q;
  logic [11:0] sens_q;
  logic [17:0] hold_q;
  logic [15:0] maxcap_q;
  logic        gate_en_q;
  logic [1:0]  mode_q;
  logic [23:0] fdecay_q;
  logic [23:0] srate_q;

  logic [23:0] mono_q;
  logic        note_q;
  logic        manual_q;

  logic [23:0] fast_q;
  logic [47:0] slow_q;
  logic        armed_q;
  logic [23:0] tpeak_q;
  logic [19:0] since_q;
  logic [9:0]  preroll_q;
  logic        wopen_q;
  logic [16:0] wlen_q;
  logic [23:0] wpeak_q;

  logic [47:0] acc_q;
  logic [47:0] diff_q;
  logic        dir_up_q;
  logic        sens_ok_q;
  logic [39:0] rt_q;
  logic        onset_q;
  logic        done_q;
  logic        kept_q;
  logic [16:0] dlen_q;

  logic        out_valid_q;
  logic        onset_out_q;
  logic        capt_out_q;
  logic        done_out_q;
  logic        kept_out_q;
  logic [16:0] len_out_q;
  logic [23:0] env_out_q;

  logic [23:0] mul_a;
  logic [23:0] mul_b;
  logic [47:0] prod;

  logic [23:0] left_u, right_u, left_abs, right_abs;
  logic [23:0] decayed;
  logic [47:0] target;
  logic [59:0] sens_sum;
  logic [39:0] rearm_max;
  logic        can_load;

  logic [19:0] since_inc;
  logic        src_trig;
  logic        trig;
  logic [16:0] len_base;
  logic [23:0] wpeak_base;
  logic [23:0] tpeak_base;
  logic        open_n;

  logic        gated;
  logic        close;
  logic        g_done;
  logic        g_kept;
  logic [16:0] g_len;
  logic        g_open;

  // Shared multiplier operand selection.
  always_comb begin
    case (state_q)
      StDecay: begin
        mul_a = fast_q;
        mul_b = fdecay_q;
      end
      StSensHi: begin
        mul_a = slow_q[47:24];
        mul_b = {12'd0, sens_q};
      end
      StSensLo: begin
        mul_a = slow_q[23:0];
        mul_b = {12'd0, sens_q};
      end
      StSlowHi: begin
        mul_a = diff_q[47:24];
        mul_b = srate_q;
      end
      StSlowLo: begin
        mul_a = diff_q[23:0];
        mul_b = srate_q;
      end
      StRearmThr: begin
        mul_a = thr_q;
        mul_b = {8'd0, KRearmThr};
      end
      StRearmPeak: begin
        mul_a = tpeak_q;
        mul_b = {8'd0, KRearmPeak};
      end
      StGate: begin
        mul_a = wpeak_q;
        mul_b = {8'd0, KGate};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign left_u = left_sample_i;
  assign right_u = right_sample_i;
  assign left_abs = left_u[23] ? (~left_u + 24'd1) : left_u;
  assign right_abs = right_u[23] ? (~right_u + 24'd1) : right_u;

  assign decayed = prod[47:24];
  assign target = {fast_q, 24'd0};
  assign sens_sum = {acc_q[35:0], 24'd0} + {24'd0, prod[35:0]};
  assign rearm_max = (rt_q > prod[39:0]) ? rt_q : prod[39:0];
  assign can_load = !out_valid_q || !out_stall_i;

  // Trigger decision for the current sample.
  always_comb begin
    since_inc = (since_q == SinceMax) ? since_q : since_q + 20'd1;
    src_trig = manual_q || ((mode_q != ModeAudio) && note_q) ||
               ((mode_q != ModeMidi) && armed_q && (fast_q > thr_q) && sens_ok_q);
    trig = src_trig && !(since_inc < {2'd0, hold_q});
    len_base = trig ? {7'd0, preroll_q} : wlen_q;
    wpeak_base = trig ? '0 : wpeak_q;
    tpeak_base = trig ? fast_q : tpeak_q;
    open_n = trig || wopen_q;
  end

  // Window close checks after the length and peak update.
  always_comb begin
    gated = gate_en_q && (wlen_q > GateDelay) && ({fast_q, 16'd0} < prod[39:0]);
    close = wopen_q && ((wlen_q >= {1'b0, maxcap_q}) || gated || (wlen_q >= DepthLimit));
    g_done = done_q || close;
    g_kept = close ? (wlen_q >= MinKeep) : kept_q;
    g_len = close ? wlen_q : dlen_q;
    g_open = wopen_q && !close;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:      if (in_valid_i) state_d = StDecay;
      StDecay:     state_d = StSensHi;
      StSensHi:    state_d = StSensLo;
      StSensLo:    state_d = StSlowHi;
      StSlowHi:    state_d = StSlowLo;
      StSlowLo:    state_d = StRearmThr;
      StRearmThr:  state_d = StRearmPeak;
      StRearmPeak: state_d = StDecide;
      StDecide:    state_d = StGate;
      StGate:      if (can_load) state_d = StIdle;
      default:     state_d = StIdle;
    endcase
  end

  assign in_stall_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 24'd265271;
      sens_q <= 12'd768;
      hold_q <= 18'd3840;
      maxcap_q <= 16'd12288;
      gate_en_q <= 1'b1;
      mode_q <= ModeAudio;
      fdecay_q <= 24'd16733720;
      srate_q <= 24'd1747;
    end else if (cfg_we_i) begin
      case (tocd_cfg_e'(cfg_idx_i))
        CfgThreshold:   thr_q <= cfg_wdata_i;
        CfgSensitivity: sens_q <= cfg_wdata_i[11:0];
        CfgHold:        hold_q <= cfg_wdata_i[17:0];
        CfgMaxCapture:  maxcap_q <= cfg_wdata_i[15:0];
        CfgGateEnable:  gate_en_q <= cfg_wdata_i[0];
        CfgTriggerMode: mode_q <= cfg_wdata_i[1:0];
        CfgFastDecay:   fdecay_q <= cfg_wdata_i;
        CfgSlowRate:    srate_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      mono_q <= (left_abs > right_abs) ? left_abs : right_abs;
      note_q <= note_trigger_i;
      manual_q <= manual_trigger_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q <= '0;
      slow_q <= '0;
      armed_q <= 1'b1;
      tpeak_q <= '0;
      since_q <= SinceMax;
      preroll_q <= '0;
      wopen_q <= 1'b0;
      wlen_q <= '0;
      wpeak_q <= '0;
      acc_q <= '0;
      diff_q <= '0;
      dir_up_q <= 1'b0;
      sens_ok_q <= 1'b0;
      rt_q <= '0;
      onset_q <= 1'b0;
      done_q <= 1'b0;
      kept_q <= 1'b0;
      dlen_q <= '0;
      out_valid_q <= 1'b0;
      onset_out_q <= 1'b0;
      capt_out_q <= 1'b0;
      done_out_q <= 1'b0;
      kept_out_q <= 1'b0;
      len_out_q <= '0;
      env_out_q <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != StGate) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StDecay: begin
          fast_q <= (mono_q > decayed) ? mono_q : decayed;
        end
        StSensHi: begin
          acc_q <= prod;
          if (target >= slow_q) begin
            diff_q <= target - slow_q;
            dir_up_q <= 1'b1;
          end else begin
            diff_q <= slow_q - target;
            dir_up_q <= 1'b0;
          end
        end
        StSensLo: begin
          sens_ok_q <= ({4'd0, fast_q, 32'd0} > sens_sum);
        end
        StSlowHi: begin
          acc_q <= prod;
        end
        StSlowLo: begin
          acc_q <= acc_q + {24'd0, prod[47:24]};
        end
        StRearmThr: begin
          rt_q <= prod[39:0];
          slow_q <= dir_up_q ? (slow_q + acc_q) : (slow_q - acc_q);
        end
        StRearmPeak: begin
          if (!armed_q && ({fast_q, 16'd0} < rearm_max)) begin
            armed_q <= 1'b1;
          end
        end
        StDecide: begin
          onset_q <= trig;
          since_q <= trig ? '0 : since_inc;
          if (trig) begin
            armed_q <= 1'b0;
          end
          done_q <= trig && wopen_q;
          kept_q <= trig && wopen_q && (wlen_q >= MinKeep);
          dlen_q <= wlen_q;
          wopen_q <= open_n;
          if (open_n) begin
            wlen_q <= len_base + 17'd1;
            wpeak_q <= (fast_q > wpeak_base) ? fast_q : wpeak_base;
            tpeak_q <= (fast_q > tpeak_base) ? fast_q : tpeak_base;
          end else begin
            tpeak_q <= tpeak_base;
          end
        end
        StGate: begin
          if (can_load) begin
            wopen_q <= g_open;
            if (preroll_q < PrerollMax) begin
              preroll_q <= preroll_q + 10'd1;
            end
            out_valid_q <= 1'b1;
            onset_out_q <= onset_q;
            capt_out_q <= g_open;
            done_out_q <= g_done;
            kept_out_q <= g_done && g_kept;
            len_out_q <= g_done ? g_len : (g_open ? wlen_q : 17'd0);
            env_out_q <= fast_q;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign onset_o = onset_out_q;
  assign capturing_o = capt_out_q;
  assign capture_done_o = done_out_q;
  assign capture_kept_o = kept_out_q;
  assign capture_length_o = len_out_q;
  assign envelope_level_o = env_out_q;

  `ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, in_valid_i && !in_stall_o,
               state_q == StDecay, "accepted sample did not start the sequence")
  `ASSERT_NEXT(a_gate_waits, clk_i, rst_ni, state_q == StGate && out_valid_q && out_stall_i,
               state_q == StGate, "result step left while output register was full")
  `ASSERT_IMPL(a_kept_needs_done, clk_i, rst_ni, out_valid_q && kept_out_q,
               done_out_q, "kept flag without a closed window")
  `ASSERT_IMPL(a_open_has_length, clk_i, rst_ni, out_valid_q && capt_out_q && !done_out_q,
               len_out_q != 17'd0, "open window reported with zero length")
  `ASSERT_IMPL(a_length_bound, clk_i, rst_ni, wopen_q && state_q == StIdle,
               wlen_q < DepthLimit, "open window reached the buffer limit")

endmodule

`default_nettype wire
